FILE: rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared widths, defaults and controller/datapath interface types of the
// free-list block allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int OFF_W = 18;   // payload offsets and request sizes
  localparam int SZ_W  = 19;   // block sizes and byte counts
  localparam int VAL_W = 20;   // offset plus size before wrapping

  localparam int DEF_SEGMENT_BYTES    = 262144;
  localparam int DEF_ALIGN_BYTES      = 8;
  localparam int SEGMENT_HEADER_BYTES = 64;
  localparam int BLOCK_HEADER_BYTES   = 32;
  localparam int MIN_BLOCK_BYTES      = 40;
  localparam int BEST_FIT_EXTRA       = 3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [4:0] {
    OP_CLR,
    OP_IDLE,
    OP_A_NEED,
    OP_A_CHK,
    OP_A_HEAD,
    OP_A_WALK,
    OP_A_BEST,
    OP_A_SEL,
    OP_A_PREP,
    OP_A_W1,
    OP_A_W2,
    OP_A_W3,
    OP_F_IX,
    OP_F_RD,
    OP_F_CUR,
    OP_F_PREV,
    OP_F_PRD,
    OP_F_PMG,
    OP_F_NIX,
    OP_F_NRD,
    OP_F_NMG,
    OP_F_HRD,
    OP_F_LNK,
    OP_F_HEAD,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic take;   // request beat taken this cycle
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic fb_short;
    logic head_empty;
    logic walk_hit;
    logic walk_more;
    logic best_more;
    logic prev_free;
    logic rsp_busy;
  } status_t;

endpackage

FILE: rtl/fba_ram.sv
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fba_ctrl.sv
// ----------------------------------------------------------------------------
// fba_ctrl
// Sequencer of the allocator: clearing pass, allocate walk and free merge
// steps, result hand-off.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic             cmd,
  input  fba_pkg::status_t sts,
  output fba_pkg::cmd_t    ctl
);
  import fba_pkg::*;

  localparam int NS = 25;

  typedef enum logic [NS-1:0] {
    S_CLR    = NS'(1) << 0,
    S_IDLE   = NS'(1) << 1,
    S_A_NEED = NS'(1) << 2,
    S_A_CHK  = NS'(1) << 3,
    S_A_HEAD = NS'(1) << 4,
    S_A_WALK = NS'(1) << 5,
    S_A_BEST = NS'(1) << 6,
    S_A_SEL  = NS'(1) << 7,
    S_A_PREP = NS'(1) << 8,
    S_A_W1   = NS'(1) << 9,
    S_A_W2   = NS'(1) << 10,
    S_A_W3   = NS'(1) << 11,
    S_F_IX   = NS'(1) << 12,
    S_F_RD   = NS'(1) << 13,
    S_F_CUR  = NS'(1) << 14,
    S_F_PREV = NS'(1) << 15,
    S_F_PRD  = NS'(1) << 16,
    S_F_PMG  = NS'(1) << 17,
    S_F_NIX  = NS'(1) << 18,
    S_F_NRD  = NS'(1) << 19,
    S_F_NMG  = NS'(1) << 20,
    S_F_HRD  = NS'(1) << 21,
    S_F_LNK  = NS'(1) << 22,
    S_F_HEAD = NS'(1) << 23,
    S_DONE   = NS'(1) << 24
  } state_t;

  state_t state, state_next;
  logic   take;

  assign take      = (state == S_IDLE) && req_valid;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:    if (sts.clr_done) state_next = S_IDLE;
      S_IDLE: begin
        if (take) begin
          state_next = (cmd == CMD_FREE) ? S_F_IX : S_A_NEED;
        end
      end
      S_A_NEED: state_next = S_A_CHK;
      S_A_CHK:  state_next = sts.fb_short ? S_DONE : S_A_HEAD;
      S_A_HEAD: state_next = sts.head_empty ? S_DONE : S_A_WALK;
      S_A_WALK: begin
        if (sts.walk_hit) begin
          state_next = sts.walk_more ? S_A_BEST : S_A_SEL;
        end else begin
          state_next = sts.walk_more ? S_A_WALK : S_DONE;
        end
      end
      S_A_BEST: state_next = sts.best_more ? S_A_BEST : S_A_SEL;
      S_A_SEL:  state_next = S_A_PREP;
      S_A_PREP: state_next = S_A_W1;
      S_A_W1:   state_next = S_A_W2;
      S_A_W2:   state_next = S_A_W3;
      S_A_W3:   state_next = S_DONE;
      S_F_IX:   state_next = S_F_RD;
      S_F_RD:   state_next = S_F_CUR;
      S_F_CUR:  state_next = sts.prev_free ? S_F_PREV : S_F_NIX;
      S_F_PREV: state_next = S_F_PRD;
      S_F_PRD:  state_next = S_F_PMG;
      S_F_PMG:  state_next = S_F_NIX;
      S_F_NIX:  state_next = S_F_NRD;
      S_F_NRD:  state_next = S_F_NMG;
      S_F_NMG:  state_next = S_F_HRD;
      S_F_HRD:  state_next = S_F_LNK;
      S_F_LNK:  state_next = S_F_HEAD;
      S_F_HEAD: state_next = S_DONE;
      S_DONE:   if (!sts.rsp_busy) state_next = S_IDLE;
      default:  state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl.take = take;
    unique case (state)
      S_CLR:    ctl.op = OP_CLR;
      S_IDLE:   ctl.op = OP_IDLE;
      S_A_NEED: ctl.op = OP_A_NEED;
      S_A_CHK:  ctl.op = OP_A_CHK;
      S_A_HEAD: ctl.op = OP_A_HEAD;
      S_A_WALK: ctl.op = OP_A_WALK;
      S_A_BEST: ctl.op = OP_A_BEST;
      S_A_SEL:  ctl.op = OP_A_SEL;
      S_A_PREP: ctl.op = OP_A_PREP;
      S_A_W1:   ctl.op = OP_A_W1;
      S_A_W2:   ctl.op = OP_A_W2;
      S_A_W3:   ctl.op = OP_A_W3;
      S_F_IX:   ctl.op = OP_F_IX;
      S_F_RD:   ctl.op = OP_F_RD;
      S_F_CUR:  ctl.op = OP_F_CUR;
      S_F_PREV: ctl.op = OP_F_PREV;
      S_F_PRD:  ctl.op = OP_F_PRD;
      S_F_PMG:  ctl.op = OP_F_PMG;
      S_F_NIX:  ctl.op = OP_F_NIX;
      S_F_NRD:  ctl.op = OP_F_NRD;
      S_F_NMG:  ctl.op = OP_F_NMG;
      S_F_HRD:  ctl.op = OP_F_HRD;
      S_F_LNK:  ctl.op = OP_F_LNK;
      S_F_HEAD: ctl.op = OP_F_HEAD;
      S_DONE:   ctl.op = OP_DONE;
      default:  ctl.op = OP_CLR;
    endcase
  end

endmodule

FILE: rtl/fba_dp.sv
// ----------------------------------------------------------------------------
// fba_dp
// Allocator datapath: header memories, slot address arithmetic, walk and
// merge registers, result register.
// ----------------------------------------------------------------------------
module fba_dp #(
  parameter int SEGMENT_BYTES = fba_pkg::DEF_SEGMENT_BYTES,
  parameter int ALIGN_BYTES   = fba_pkg::DEF_ALIGN_BYTES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fba_pkg::cmd_t             ctl,
  output fba_pkg::status_t          sts,
  input  logic [fba_pkg::OFF_W-1:0] request_bytes,
  input  logic [fba_pkg::OFF_W-1:0] block_offset,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic                      status,
  output logic [fba_pkg::OFF_W-1:0] payload_offset,
  output logic [fba_pkg::OFF_W-1:0] granted_bytes,
  output logic [fba_pkg::SZ_W-1:0]  released_bytes,
  output logic [fba_pkg::SZ_W-1:0]  avail_bytes
);
  import fba_pkg::*;

  localparam int SLOTS   = (SEGMENT_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int IXW     = $clog2(SLOTS);
  localparam int SW      = $clog2(SLOTS + 1);
  localparam int BW      = $clog2(BEST_FIT_EXTRA + 1);
  localparam int AW      = $clog2(SEGMENT_BYTES);
  localparam int MODK    = VAL_W - AW;
  localparam int DIVL    = $clog2(ALIGN_BYTES);
  localparam int DIVK    = VAL_W + DIVL;
  localparam int MW      = VAL_W + 2;
  localparam int MREC    = ((1 << DIVK) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int HDR_BLK = ((BLOCK_HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                           * ALIGN_BYTES;
  localparam int HDR_SEG = ((SEGMENT_HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                           * ALIGN_BYTES;
  localparam int HEAD_IX = (HDR_SEG % SEGMENT_BYTES) / ALIGN_BYTES;
  localparam int BODY_IX = ((HDR_SEG + HDR_BLK) % SEGMENT_BYTES) / ALIGN_BYTES;
  localparam int FB_INT  = SEGMENT_BYTES - HDR_SEG - 2 * HDR_BLK;
  localparam logic [SZ_W-1:0] FB_RST = SZ_W'(FB_INT);
  localparam int BODY_INT = int'(FB_RST) - HDR_BLK;
  localparam logic [SZ_W-1:0] BODY_SZ = SZ_W'(BODY_INT);
  localparam int TAIL_IX = ((BODY_IX * ALIGN_BYTES + int'(BODY_SZ)) % SEGMENT_BYTES)
                           / ALIGN_BYTES;
  localparam int BACK    = HDR_BLK % SEGMENT_BYTES;

  localparam logic [IXW-1:0] HEAD = IXW'(HEAD_IX);
  localparam logic [IXW-1:0] BODY = IXW'(BODY_IX);
  localparam logic [IXW-1:0] TAIL = IXW'(TAIL_IX);

  // value modulo the segment size, restoring subtract of shifted segment sizes
  function automatic logic [VAL_W-1:0] mod_seg(input logic [VAL_W-1:0] v);
    logic [VAL_W:0] r;
    logic [VAL_W:0] d;
    r = {1'b0, v};
    for (int k = MODK; k >= 0; k--) begin
      d = (VAL_W + 1)'(SEGMENT_BYTES) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[VAL_W-1:0];
  endfunction

  // floor division by the alignment through a reciprocal
  function automatic logic [VAL_W-1:0] div_align(input logic [VAL_W-1:0] v);
    logic [VAL_W+MW-1:0] prod;
    prod = {{MW{1'b0}}, v} * {{VAL_W{1'b0}}, MW'(MREC)};
    return VAL_W'(prod >> DIVK);
  endfunction

  function automatic logic [IXW-1:0] slot_of(input logic [VAL_W-1:0] v);
    return IXW'(div_align(mod_seg(v)));
  endfunction

  function automatic logic [VAL_W-1:0] off_of(input logic [IXW-1:0] i);
    return VAL_W'(VAL_W'(i) * VAL_W'(ALIGN_BYTES));
  endfunction

  // header memories
  logic            sz_we, ps_we, fn_we, fp_we;
  logic [IXW-1:0]  sz_wa, ps_wa, fn_wa, fp_wa;
  logic [IXW-1:0]  sz_ra, ps_ra, fn_ra, fp_ra;
  logic [SZ_W-1:0] sz_wd, ps_wd, sz_rd, ps_rd;
  logic [IXW-1:0]  fn_wd, fp_wd, fn_rd, fp_rd;

  fba_ram #(.WIDTH(SZ_W), .DEPTH(SLOTS)) u_size_ram (
    .clk(clk), .we(sz_we), .waddr(sz_wa), .wdata(sz_wd), .raddr(sz_ra), .rdata(sz_rd)
  );
  fba_ram #(.WIDTH(SZ_W), .DEPTH(SLOTS)) u_prev_size_ram (
    .clk(clk), .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd)
  );
  fba_ram #(.WIDTH(IXW), .DEPTH(SLOTS)) u_next_ram (
    .clk(clk), .we(fn_we), .waddr(fn_wa), .wdata(fn_wd), .raddr(fn_ra), .rdata(fn_rd)
  );
  fba_ram #(.WIDTH(IXW), .DEPTH(SLOTS)) u_prev_ram (
    .clk(clk), .we(fp_we), .waddr(fp_wa), .wdata(fp_wd), .raddr(fp_ra), .rdata(fp_rd)
  );

  // working registers
  logic [IXW-1:0]   clr_cnt;
  logic [OFF_W-1:0] req_bytes;
  logic [OFF_W-1:0] blk_off;
  logic [SZ_W-1:0]  need;
  logic [SZ_W-1:0]  fb;
  logic [IXW-1:0]   cur;
  logic [SW-1:0]    steps;
  logic [BW-1:0]    best_i;
  logic [IXW-1:0]   found;
  logic [SZ_W-1:0]  found_size;
  logic             split;
  logic [IXW-1:0]   idx1, idx2;
  logic [IXW-1:0]   fp_c, fn_c;
  logic [SZ_W-1:0]  size_c;
  logic [VAL_W-1:0] prev_gap;
  logic             res_status;
  logic [OFF_W-1:0] res_pay, res_gr;
  logic [SZ_W-1:0]  res_rel;

  logic             hit, better, split_now;
  logic [SW-1:0]    steps_inc;
  logic [BW-1:0]    best_inc;
  logic [SZ_W-1:0]  rest, sc_fin, pmg_sum, nmg_sum;
  logic [IXW-1:0]   fp_fin, head_tgt;
  logic [VAL_W-1:0] fb_sum;
  logic [SZ_W-1:0]  fb_add;
  logic             rsp_load;

  assign hit       = (sz_rd >= need);
  assign steps_inc = steps + SW'(1);
  assign better    = hit && (sz_rd < found_size);
  assign best_inc  = best_i + BW'(1);
  assign split_now = !(VAL_W'(found_size) < VAL_W'(need) + VAL_W'(2 * MIN_BLOCK_BYTES));
  assign rest      = found_size - need;
  // the remainder's prev link may be overwritten when the next free block is itself
  assign fp_fin    = (fn_c == idx1) ? idx1 : fp_c;
  assign sc_fin    = split ? ((idx1 == found) ? rest : need) : found_size;
  assign pmg_sum   = sz_rd + size_c;
  assign nmg_sum   = size_c + sz_rd;
  assign head_tgt  = (cur == HEAD) ? cur : fn_c;
  assign fb_sum    = VAL_W'(fb) + VAL_W'(sz_rd);
  assign fb_add    = (fb_sum > VAL_W'(SEGMENT_BYTES)) ? SZ_W'(SEGMENT_BYTES)
                                                      : fb_sum[SZ_W-1:0];
  assign rsp_load  = (ctl.op == OP_DONE) && !(rsp_valid && rsp_stall);

  always_comb begin
    sts.clr_done   = (clr_cnt == IXW'(SLOTS - 1));
    sts.fb_short   = (fb < need);
    sts.head_empty = (fn_rd == '0);
    sts.walk_hit   = hit;
    sts.walk_more  = (fn_rd != '0) && (hit || (steps_inc < SW'(SLOTS)));
    sts.best_more  = (fn_rd != '0) && (best_inc < BW'(BEST_FIT_EXTRA));
    sts.prev_free  = (ps_rd != '0);
    sts.rsp_busy   = rsp_valid && rsp_stall;
  end

  // memory ports
  always_comb begin
    sz_we = 1'b0; sz_wa = cur; sz_wd = '0; sz_ra = cur;
    ps_we = 1'b0; ps_wa = cur; ps_wd = '0; ps_ra = cur;
    fn_we = 1'b0; fn_wa = cur; fn_wd = '0; fn_ra = cur;
    fp_we = 1'b0; fp_wa = cur; fp_wd = '0; fp_ra = cur;
    case (ctl.op) inside
      OP_CLR: begin
        sz_we = 1'b1; sz_wa = clr_cnt;
        ps_we = 1'b1; ps_wa = clr_cnt;
        fn_we = 1'b1; fn_wa = clr_cnt;
        fp_we = 1'b1; fp_wa = clr_cnt;
        sz_wd = (clr_cnt == BODY) ? BODY_SZ : '0;
        ps_wd = (clr_cnt == TAIL) ? BODY_SZ : '0;
        if (clr_cnt == TAIL) begin
          fn_wd = '0;
        end else if (clr_cnt == BODY) begin
          fn_wd = TAIL;
        end else if (clr_cnt == HEAD) begin
          fn_wd = BODY;
        end
        if (clr_cnt == TAIL) begin
          fp_wd = BODY;
        end else if (clr_cnt == BODY) begin
          fp_wd = HEAD;
        end
      end
      OP_A_CHK: fn_ra = HEAD;
      OP_A_HEAD, OP_A_WALK, OP_A_BEST: begin
        sz_ra = fn_rd;
        fn_ra = fn_rd;
      end
      OP_A_SEL: begin
        fn_ra = found;
        fp_ra = found;
      end
      OP_A_W1: begin
        ps_we = 1'b1; ps_wa = idx1; ps_wd = '0;
        if (split) begin
          sz_we = 1'b1; sz_wa = found; sz_wd = need;
          fn_we = 1'b1; fn_wa = idx1;  fn_wd = fn_c;
          fp_we = 1'b1; fp_wa = idx1;  fp_wd = fp_c;
        end else begin
          fn_we = 1'b1; fn_wa = fp_c; fn_wd = fn_c;
          fp_we = 1'b1; fp_wa = fn_c; fp_wd = fp_c;
        end
      end
      OP_A_W2: begin
        if (split) begin
          sz_we = 1'b1; sz_wa = idx1;   sz_wd = rest;
          ps_we = 1'b1; ps_wa = idx2;   ps_wd = rest;
          fn_we = 1'b1; fn_wa = fp_fin; fn_wd = idx1;
          fp_we = 1'b1; fp_wa = fn_c;   fp_wd = idx1;
        end
      end
      OP_A_W3: begin
        fn_we = 1'b1; fn_wa = found; fn_wd = '0;
      end
      OP_F_NRD: begin
        sz_ra = idx1;
        fn_ra = idx1;
        fp_ra = idx1;
      end
      OP_F_PMG: begin
        fp_we = 1'b1; fp_wa = fn_rd; fp_wd = fp_rd;
        fn_we = 1'b1; fn_wa = fp_rd; fn_wd = fn_rd;
        sz_we = 1'b1; sz_wa = cur;   sz_wd = pmg_sum;
      end
      OP_F_NMG: begin
        if (fn_rd != '0) begin
          fp_we = 1'b1; fp_wa = fn_rd; fp_wd = fp_rd;
          fn_we = 1'b1; fn_wa = fp_rd; fn_wd = fn_rd;
          sz_we = 1'b1; sz_wa = cur;   sz_wd = nmg_sum;
        end
      end
      OP_F_HRD: fn_ra = HEAD;
      OP_F_LNK: begin
        ps_we = 1'b1; ps_wa = idx1; ps_wd = size_c;
        fn_we = 1'b1; fn_wa = cur;  fn_wd = fn_rd;
        fp_we = 1'b1; fp_wa = cur;  fp_wd = HEAD;
      end
      OP_F_HEAD: begin
        fn_we = 1'b1; fn_wa = HEAD;     fn_wd = cur;
        fp_we = 1'b1; fp_wa = head_tgt; fp_wd = cur;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      fb        <= FB_RST;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.op == OP_CLR) begin
        clr_cnt <= clr_cnt + IXW'(1);
      end
      if (ctl.op == OP_A_W3) begin
        fb <= (fb >= sc_fin) ? fb - sc_fin : '0;
      end else if (ctl.op == OP_F_CUR) begin
        fb <= fb_add;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      req_bytes  <= request_bytes;
      blk_off    <= block_offset;
      res_status <= 1'b0;
      res_pay    <= '0;
      res_gr     <= '0;
      res_rel    <= '0;
    end
    case (ctl.op)
      OP_A_NEED: begin
        need <= SZ_W'(VAL_W'(div_align(VAL_W'(req_bytes) + VAL_W'(HDR_BLK + ALIGN_BYTES - 1))
                * VAL_W'(ALIGN_BYTES)));
      end
      OP_A_CHK: begin
        if (fb < need) res_status <= 1'b1;
      end
      OP_A_HEAD: begin
        if (fn_rd == '0) res_status <= 1'b1;
        cur   <= fn_rd;
        steps <= '0;
      end
      OP_A_WALK: begin
        cur <= fn_rd;
        if (hit) begin
          found      <= cur;
          found_size <= sz_rd;
          best_i     <= '0;
        end else begin
          steps <= steps_inc;
          if (!((fn_rd != '0) && (steps_inc < SW'(SLOTS)))) res_status <= 1'b1;
        end
      end
      OP_A_BEST: begin
        cur    <= fn_rd;
        best_i <= best_inc;
        if (better) begin
          found      <= cur;
          found_size <= sz_rd;
        end
      end
      OP_A_SEL: begin
        split <= split_now;
        idx1  <= slot_of(off_of(found) + VAL_W'(split_now ? need : found_size));
      end
      OP_A_PREP: begin
        fp_c <= fp_rd;
        fn_c <= fn_rd;
        idx2 <= slot_of(off_of(idx1) + VAL_W'(rest));
      end
      OP_A_W3: begin
        res_gr  <= OFF_W'(sc_fin - SZ_W'(HDR_BLK));
        res_pay <= OFF_W'(off_of(found) + VAL_W'(HDR_BLK));
      end
      OP_F_IX: begin
        cur <= slot_of(VAL_W'(blk_off) + VAL_W'(SEGMENT_BYTES - BACK));
      end
      OP_F_CUR: begin
        res_rel  <= sz_rd;
        size_c   <= sz_rd;
        prev_gap <= mod_seg(VAL_W'(ps_rd));
      end
      OP_F_PREV: begin
        // the free block in front becomes the merge base
        cur <= slot_of(off_of(cur) + VAL_W'(SEGMENT_BYTES) - prev_gap);
      end
      OP_F_PMG: size_c <= pmg_sum;
      OP_F_NIX: idx1 <= slot_of(off_of(cur) + VAL_W'(size_c));
      OP_F_NMG: begin
        if (fn_rd != '0) size_c <= nmg_sum;
      end
      OP_F_HRD: idx1 <= slot_of(off_of(cur) + VAL_W'(size_c));
      OP_F_LNK: fn_c <= fn_rd;
      default: ;
    endcase
    if (rsp_load) begin
      status         <= res_status;
      payload_offset <= res_pay;
      granted_bytes  <= res_gr;
      released_bytes <= res_rel;
      avail_bytes    <= fb;
    end
  end

endmodule

FILE: rtl/free_list_block_allocator_top.sv
// ----------------------------------------------------------------------------
// free_list_block_allocator_top
// First-fit free-list allocator with split and coalescing over one segment.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the header memories, one
// slot per cycle over all SEGMENT_BYTES / ALIGN_BYTES slots (32768 by default),
// and holds req_stall high until it ends. One request beat is worked at a time.
// An allocate walks the free list from its head and, after the first fit, looks
// at up to 3 more entries for a smaller fit; the walk reads the header memories
// one entry per cycle, and a failed allocate ends early. A free runs a sequence
// of header read-modify-write steps, and passes through S_F_PREV, S_F_PRD and
// S_F_PMG when it merges with the free block in front.
// Results sit in an output register, so the next request beat is taken while
// a result still waits on rsp_stall.
module free_list_block_allocator_top #(
  parameter int SEGMENT_BYTES = fba_pkg::DEF_SEGMENT_BYTES,
  parameter int ALIGN_BYTES   = fba_pkg::DEF_ALIGN_BYTES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      cmd,
  input  logic [fba_pkg::OFF_W-1:0] request_bytes,
  input  logic [fba_pkg::OFF_W-1:0] block_offset,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic                      status,
  output logic [fba_pkg::OFF_W-1:0] payload_offset,
  output logic [fba_pkg::OFF_W-1:0] granted_bytes,
  output logic [fba_pkg::SZ_W-1:0]  released_bytes,
  output logic [fba_pkg::SZ_W-1:0]  avail_bytes
);
  import fba_pkg::*;

  cmd_t    ctl;
  status_t sts;

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts),
    .ctl       (ctl)
  );

  fba_dp #(
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .ALIGN_BYTES   (ALIGN_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .request_bytes  (request_bytes),
    .block_offset   (block_offset),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .payload_offset (payload_offset),
    .granted_bytes  (granted_bytes),
    .released_bytes (released_bytes),
    .avail_bytes    (avail_bytes)
  );

endmodule
